// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the lattice neighbor block.
// Each macro expands to a concurrent assertion, or to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif
`endif

// File: hw/rtl/plni_pkg.sv
// Shared types and constants of the periodic lattice neighbor block.
// Used by plni_divider and periodic_lattice_neighbor_index_top; depends on nothing.
`default_nettype none

package plni_pkg;

   localparam int SITE_W      = 20;
   localparam int DIR_W       = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_EXTENT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_EXTENT  = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] AXIS_T = 2'd3;

   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = SITE_W / DIV_BITS_PER_STAGE;

   typedef logic [SITE_W-1:0] site_type;
   typedef logic [DIR_W-1:0]  dir_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/plni_divider.sv
// Pipelined restoring divider: site-wide dividend by a narrow lattice extent.
// Carries a side payload alongside; depends on plni_pkg.
`default_nettype none

module plni_divider #(
   parameter int EXT_W  = 6,
   parameter int SIDE_W = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire plni_pkg::pipe_ctl_type  in_ctl,
   input  wire plni_pkg::site_type      in_dividend,
   input  wire [SIDE_W-1:0]             in_side,
   input  wire [EXT_W-1:0]              divisor,
   output logic                         out_valid,
   output plni_pkg::site_type           out_quot,
   output logic [EXT_W-1:0]             out_rem,
   output logic [SIDE_W-1:0]            out_side
);

   localparam int STAGES = plni_pkg::DIV_STAGES;
   localparam int BPS    = plni_pkg::DIV_BITS_PER_STAGE;
   localparam int SW     = plni_pkg::SITE_W;

   logic [STAGES-1:0]  v_ff;
   logic [EXT_W-1:0]   rem_ff [STAGES];
   plni_pkg::site_type acc_ff [STAGES];
   logic [SIDE_W-1:0]  side_ff [STAGES];
   logic [EXT_W-1:0]   rem_in [STAGES];
   plni_pkg::site_type acc_in [STAGES];

   function automatic logic [EXT_W+SW-1:0] div_steps(
      input logic [EXT_W-1:0]   rem,
      input plni_pkg::site_type acc,
      input logic [EXT_W-1:0]   d
   );
      logic [EXT_W:0]     part;
      logic [EXT_W-1:0]   r;
      plni_pkg::site_type a;
      r = rem;
      a = acc;
      for (int i = 0; i < BPS; i++) begin
         part = {r, a[SW-1]};
         a    = {a[SW-2:0], 1'b0};
         if (part >= {1'b0, d}) begin
            part = part - {1'b0, d};
            a[0] = 1'b1;
         end
         r = part[EXT_W-1:0];
      end
      return {r, a};
   endfunction

   assign {rem_in[0], acc_in[0]} = div_steps('0, in_dividend, divisor);

   for (genvar s = 1; s < STAGES; s++) begin : g_stage
      assign {rem_in[s], acc_in[s]} = div_steps(rem_ff[s-1], acc_ff[s-1], divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (in_ctl.advance) begin
         v_ff <= {v_ff[STAGES-2:0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            acc_ff[s] <= acc_in[s];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_quot  = acc_ff[STAGES-1];
   assign out_rem   = rem_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/periodic_lattice_neighbor_index_top.sv
// Neighbor index of a site on a periodic 4-D lattice.
// Depends on plni_pkg, plni_divider and assert_macros.svh.
//
// Usage:
//   req channel: one beat carries a linear site index (x fastest, then y, z, t)
//   and a direction code. rsp channel: one beat carries the neighbor index and
//   an invalid flag (bad direction code or site beyond the lattice volume; the
//   neighbor index is then 0). csr port: register 0 sets the spatial extent,
//   register 1 the time extent; values are saturated into 1..MAX_EXTENT.
//   Write them only while no beat is in flight.
// Throughput: one beat per cycle, sustained while the skid register is empty.
// Pipeline: three chained 5-stage restoring dividers (4 quotient bits per stage)
//   peel off x, y and z; a step register steps the coordinate, two registers
//   rebuild the index through a multiply-add each, and the last multiply-add
//   feeds the rsp output register.
// Reset: clears all valid bits and loads both extents with 8 (or MAX_EXTENT if
//   that is smaller).
// Stall: a one-beat skid register sits behind the rsp output register; req_tready
//   drops only while the skid register is full, and the pipeline then holds.
`default_nettype none
`include "assert_macros.svh"

module periodic_lattice_neighbor_index_top #(
   parameter int MAX_EXTENT = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // req_tdata: site[19:0], direction[23:20]
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [plni_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: neighbor[19:0], zero[23:20]
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [plni_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: invalid[0]
   output logic                                rsp_tuser,
   input  wire                                 csr_we,
   input  wire [plni_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [plni_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SW     = plni_pkg::SITE_W;
   localparam int DW     = plni_pkg::DIR_W;
   localparam int EXT_W  = (MAX_EXTENT < 63) ? $clog2(MAX_EXTENT + 1) : plni_pkg::CSR_DATA_W;
   localparam int RESET_EXT = (MAX_EXTENT < 8) ? MAX_EXTENT : 8;
   localparam int A_W    = 2 * EXT_W;
   localparam int B_W    = 3 * EXT_W;
   localparam int NB_W   = 4 * EXT_W;

   // Extent registers
   logic [EXT_W-1:0] ns_ff;
   logic [EXT_W-1:0] nt_ff;
   logic [EXT_W-1:0] csr_ext;

   always_comb begin
      if (csr_wdata == '0) begin
         csr_ext = EXT_W'(1);
      end else if (int'(csr_wdata) > MAX_EXTENT) begin
         csr_ext = EXT_W'(MAX_EXTENT);
      end else begin
         csr_ext = EXT_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff <= EXT_W'(RESET_EXT);
         nt_ff <= EXT_W'(RESET_EXT);
      end else if (csr_we) begin
         case (csr_index)
            plni_pkg::CSR_SPACE_EXTENT: begin
               ns_ff <= csr_ext;
            end
            plni_pkg::CSR_TIME_EXTENT: begin
               nt_ff <= csr_ext;
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline control
   logic adv;
   logic skid_v_ff;
   logic rsp_v_ff;
   plni_pkg::pipe_ctl_type ctl_req;
   plni_pkg::pipe_ctl_type ctl_d0;
   plni_pkg::pipe_ctl_type ctl_d1;

   assign adv        = !skid_v_ff;
   assign req_tready = adv;

   // Coordinate extraction
   logic                d0_v, d1_v, d2_v;
   plni_pkg::site_type  d0_quot, d1_quot, d2_quot;
   logic [EXT_W-1:0]    d0_rem, d1_rem, d2_rem;
   logic [DW-1:0]       d0_side;
   logic [DW+EXT_W-1:0] d1_side;
   logic [DW+2*EXT_W-1:0] d2_side;

   assign ctl_req = '{advance: adv, valid: req_tvalid};
   assign ctl_d0  = '{advance: adv, valid: d0_v};
   assign ctl_d1  = '{advance: adv, valid: d1_v};

   plni_divider #(.EXT_W(EXT_W), .SIDE_W(DW)) u_div_x (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ctl_req),
      .in_dividend (req_tdata[SW-1:0]),
      .in_side     (req_tdata[SW+DW-1:SW]),
      .divisor     (ns_ff),
      .out_valid   (d0_v),
      .out_quot    (d0_quot),
      .out_rem     (d0_rem),
      .out_side    (d0_side)
   );

   plni_divider #(.EXT_W(EXT_W), .SIDE_W(DW + EXT_W)) u_div_y (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ctl_d0),
      .in_dividend (d0_quot),
      .in_side     ({d0_rem, d0_side}),
      .divisor     (ns_ff),
      .out_valid   (d1_v),
      .out_quot    (d1_quot),
      .out_rem     (d1_rem),
      .out_side    (d1_side)
   );

   plni_divider #(.EXT_W(EXT_W), .SIDE_W(DW + 2 * EXT_W)) u_div_z (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ctl_d1),
      .in_dividend (d1_quot),
      .in_side     ({d1_rem, d1_side}),
      .divisor     (ns_ff),
      .out_valid   (d2_v),
      .out_quot    (d2_quot),
      .out_rem     (d2_rem),
      .out_side    (d2_side)
   );

   // Step stage
   function automatic logic [EXT_W-1:0] step_coord(
      input logic [EXT_W-1:0] c,
      input logic [EXT_W-1:0] n,
      input logic             back
   );
      logic [EXT_W:0] inc;
      inc = {1'b0, c} + (EXT_W + 1)'(1);
      if (back) begin
         return (c == '0) ? n - EXT_W'(1) : c - EXT_W'(1);
      end
      return (inc >= {1'b0, n}) ? '0 : inc[EXT_W-1:0];
   endfunction

   plni_pkg::dir_type dir_w;
   logic [EXT_W-1:0]  x_w, y_w, z_w, t_w;
   logic [EXT_W-1:0]  sx_in, sy_in, sz_in, st_in;
   logic              sinv_in;
   logic              s_v_ff, s_inv_ff;
   logic [EXT_W-1:0]  sx_ff, sy_ff, sz_ff, st_ff;

   assign dir_w = d2_side[DW-1:0];
   assign x_w   = d2_side[DW +: EXT_W];
   assign y_w   = d2_side[DW+EXT_W +: EXT_W];
   assign z_w   = d2_rem;
   assign t_w   = d2_quot[EXT_W-1:0];

   always_comb begin
      sinv_in = dir_w[DW-1] || (d2_quot >= SW'(nt_ff));
      sx_in   = x_w;
      sy_in   = y_w;
      sz_in   = z_w;
      st_in   = t_w;
      case (dir_w[2:1])
         plni_pkg::AXIS_X: sx_in = step_coord(x_w, ns_ff, dir_w[0]);
         plni_pkg::AXIS_Y: sy_in = step_coord(y_w, ns_ff, dir_w[0]);
         plni_pkg::AXIS_Z: sz_in = step_coord(z_w, ns_ff, dir_w[0]);
         plni_pkg::AXIS_T: st_in = step_coord(t_w, nt_ff, dir_w[0]);
         default: st_in = t_w;
      endcase
   end

   // Rebuild stages
   logic             a_v_ff, a_inv_ff, b_v_ff, b_inv_ff;
   logic [EXT_W-1:0] ax_ff, ay_ff, bx_ff;
   logic [A_W-1:0]   a_in, a_ff;
   logic [B_W-1:0]   b_in, b_ff;
   logic [NB_W-1:0]  nb_w;
   logic [SW+NB_W-1:0] nb_wide;
   plni_pkg::site_type nb_in;
   logic             incoming;

   assign a_in    = A_W'(ns_ff) * A_W'(st_ff) + A_W'(sz_ff);
   assign b_in    = B_W'(ns_ff) * B_W'(a_ff) + B_W'(ay_ff);
   assign nb_w    = NB_W'(ns_ff) * NB_W'(b_ff) + NB_W'(bx_ff);
   assign nb_wide = (SW + NB_W)'(nb_w);
   assign nb_in   = b_inv_ff ? '0 : nb_wide[SW-1:0];
   assign incoming = adv && b_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (adv) begin
         s_v_ff <= d2_v;
         a_v_ff <= s_v_ff;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_inv_ff <= sinv_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sz_ff    <= sz_in;
         st_ff    <= st_in;
         a_inv_ff <= s_inv_ff;
         ax_ff    <= sx_ff;
         ay_ff    <= sy_ff;
         a_ff     <= a_in;
         b_inv_ff <= a_inv_ff;
         bx_ff    <= ax_ff;
         b_ff     <= b_in;
      end
   end

   // Output register and skid
   plni_pkg::site_type rsp_nb_ff, skid_nb_ff;
   logic               rsp_inv_ff, skid_inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= incoming;
         end
      end else if (incoming) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            rsp_nb_ff  <= skid_nb_ff;
            rsp_inv_ff <= skid_inv_ff;
         end else if (incoming) begin
            rsp_nb_ff  <= nb_in;
            rsp_inv_ff <= b_inv_ff;
         end
      end else if (incoming) begin
         skid_nb_ff  <= nb_in;
         skid_inv_ff <= b_inv_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(plni_pkg::RSP_DATA_W - SW){1'b0}}, rsp_nb_ff};
   assign rsp_tuser  = rsp_inv_ff;

   `ASSERT_IMPLIES(a_skid_needs_rsp, clock, reset, skid_v_ff, rsp_v_ff)
   `ASSERT_IMPLIES(a_skid_on_stall, clock, reset, $rose(skid_v_ff), $past(rsp_v_ff && !rsp_tready))
   `ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_v_ff && rsp_inv_ff, rsp_nb_ff == '0)
   `ASSERT_ALWAYS(a_extent_range, clock, reset, (ns_ff != '0) && (ns_ff <= MAX_EXTENT) && (nt_ff != '0) && (nt_ff <= MAX_EXTENT))

endmodule

`default_nettype wire
